// ----- hw/rtl/gps_time_calendar_converter_macros.svh -----
// ---------------------------------------------------------------------------
// GPS time / calendar converter assertion macros
// Concurrent checks shared by the converter RTL, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef GPS_TIME_CALENDAR_CONVERTER_MACROS_SVH
`define GPS_TIME_CALENDAR_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define GTCC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GTCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gtcc_pkg.sv -----
// ---------------------------------------------------------------------------
// GPS time / calendar converter package
// Field layout, command codes, scaled-integer constants and month table.
// ---------------------------------------------------------------------------
package gtcc_pkg;

    localparam int WEEK_BITS_DEF = 13;

    // field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int MS_W    = 16;
    localparam int WEEK_W  = 13;
    localparam int WMS_W   = 30;

    localparam int FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + MS_W
                              + WEEK_W + WMS_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int TUSER_W  = 1;

    // command and status codes
    localparam logic CMD_TO_GPS = 1'b0;
    localparam logic CMD_TO_CAL = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_RANGE   = 1'b1;

    // input item, year in the lowest bits
    typedef struct packed {
        logic [WMS_W-1:0]   week_ms;
        logic [WEEK_W-1:0]  week;
        logic [MS_W-1:0]    second_ms;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_item;

    // result item, out_year in the lowest bits
    typedef struct packed {
        logic [WMS_W-1:0]   out_week_ms;
        logic [WEEK_W-1:0]  out_week;
        logic [MS_W-1:0]    out_second_ms;
        logic [MIN_W-1:0]   out_minute;
        logic [HOUR_W-1:0]  out_hour;
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
    } t_result;

    // time constants
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;

    // two-digit year handling
    localparam logic [YEAR_W-1:0] YEAR_2DIG_LIM = 12'd100;
    localparam logic [YEAR_W-1:0] YEAR_PIVOT    = 12'd80;
    localparam logic [YEAR_W-1:0] CENT_19       = 12'd1900;
    localparam logic [YEAR_W-1:0] CENT_20       = 12'd2000;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [4:0]         MONTHS_YR = 5'd12;
    localparam logic [4:0]         E_WRAP    = 5'd14;

    // calendar to day count: MJD offset 679019 plus GPS epoch MJD 44244
    localparam logic [20:0] CAL_DAY_OFF  = 21'd723263;
    // day count to calendar: epoch MJD 44244 + 2400001 + 1537
    localparam logic [21:0] CAL_B_OFF    = 22'd2445782;
    localparam logic [28:0] CAL_C_SUB    = 29'd12210;
    localparam logic [12:0] CAL_YEAR_OFF = 13'd4715;
    localparam logic [9:0]  DAYS_PER_YR  = 10'd365;

    // reciprocal multipliers, exact over the operand ranges used
    localparam int DIV7_SH = 23;
    localparam longint unsigned DIV7_M = ((64'd1 << DIV7_SH) + 64'd6) / 64'd7;

    localparam int DAY_PRE = 10;   // 86400000 = 2^10 * 84375
    localparam int DAY_SH  = 37;
    localparam longint unsigned DAY_ODD = 64'd84375;
    localparam longint unsigned DAY_M = ((64'd1 << DAY_SH) + DAY_ODD - 64'd1) / DAY_ODD;

    localparam int HR_PRE = 7;     // 3600000 = 2^7 * 28125
    localparam int HR_SH  = 35;
    localparam longint unsigned HR_ODD = 64'd28125;
    localparam longint unsigned HR_M = ((64'd1 << HR_SH) + HR_ODD - 64'd1) / HR_ODD;

    localparam int MIN_PRE = 5;    // 60000 = 2^5 * 1875
    localparam int MIN_SH  = 28;
    localparam longint unsigned MIN_ODD = 64'd1875;
    localparam longint unsigned MIN_M = ((64'd1 << MIN_SH) + MIN_ODD - 64'd1) / MIN_ODD;

    localparam int C_SH = 44;      // divide by 36525
    localparam longint unsigned C_DIV = 64'd36525;
    localparam longint unsigned C_M = ((64'd1 << C_SH) + C_DIV - 64'd1) / C_DIV;

    // floor(30.6001 * k)
    function automatic logic [8:0] f_month_floor(input logic [4:0] k);
        case (k)
            5'd1:    return 9'd30;
            5'd2:    return 9'd61;
            5'd3:    return 9'd91;
            5'd4:    return 9'd122;
            5'd5:    return 9'd153;
            5'd6:    return 9'd183;
            5'd7:    return 9'd214;
            5'd8:    return 9'd244;
            5'd9:    return 9'd275;
            5'd10:   return 9'd306;
            5'd11:   return 9'd336;
            5'd12:   return 9'd367;
            5'd13:   return 9'd397;
            5'd14:   return 9'd428;
            5'd15:   return 9'd459;
            5'd16:   return 9'd489;
            default: return 9'd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/gps_time_calendar_converter.sv -----
// ---------------------------------------------------------------------------
// GPS time / calendar converter: calendar date <-> GPS week and ms of week
// Pipeline: 7 register stages from input transaction to result valid.
// Throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined datapath.
// Reset: synchronous active-low i_rst_n clears the stage valid bits only.
// ---------------------------------------------------------------------------
`include "gps_time_calendar_converter_macros.svh"

module gps_time_calendar_converter #(
    parameter int WEEK_BITS = gtcc_pkg::WEEK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: year, month, day, hour, minute, second_ms, week, week_ms, zero pad
    input  logic [gtcc_pkg::TDATA_W-1:0] i_s_axis_tdata,
    // tuser: command
    input  logic [gtcc_pkg::TUSER_W-1:0] i_s_axis_tuser,
    // master side
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // tdata: out_year, out_month, out_day, out_hour, out_minute, out_second_ms,
    //        out_week, out_week_ms, zero pad
    output logic [gtcc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status
    output logic [gtcc_pkg::TUSER_W-1:0] o_m_axis_tuser
);

    import gtcc_pkg::*;

    localparam int N_STAGES = 7;

    // Both directions travel side by side through every stage; the command
    // bit picks the lane at the output register.
    //
    // Calendar to GPS lane:
    //   s1  year mapping, month fold, time of day in ms
    //   s2  365*y + y/4 + floor(30.6001*(m+1)) + day; fold time of day into a day
    //   s3  remove MJD and epoch offsets, flag dates before the epoch
    //   s4  days / 7 by reciprocal
    //   s5  day of week, week range check
    //   s6  ms of week
    // GPS to calendar lane:
    //   s1  week*7, ms / day by reciprocal
    //   s2  shifted day number b, ms of day
    //   s3  100*b - 12210, hour by reciprocal
    //   s4  c = year-ish count by reciprocal, ms remainder of hour
    //   s5  day of year x = b - floor(365.25c), minute by reciprocal
    //   s6  month index e by threshold search, seconds in ms
    //   s7  month, day and year decode

    typedef struct packed {
        logic        cmd;
        logic [11:0] y;
        logic [4:0]  k;
        logic [4:0]  day;
        logic [26:0] tod;
        logic [15:0] wk7;
        logic        wk_err;
        logic [29:0] wms;
        logic [3:0]  dq;
    } t_s1;

    typedef struct packed {
        logic        cmd;
        logic [20:0] yd;
        logic        tod_ge;
        logic [26:0] tod_rem;
        logic        wk_err;
        logic [21:0] b;
        logic [26:0] msday;
    } t_s2;

    typedef struct packed {
        logic        cmd;
        logic        neg;
        logic [19:0] td;
        logic [26:0] tod_rem;
        logic        wk_err;
        logic [21:0] b;
        logic [27:0] nc;
        logic [26:0] msday;
        logic [4:0]  hour;
    } t_s3;

    typedef struct packed {
        logic        cmd;
        logic        neg;
        logic [19:0] td;
        logic [16:0] wq;
        logic [26:0] tod_rem;
        logic        wk_err;
        logic [21:0] b;
        logic [12:0] c;
        logic [4:0]  hour;
        logic [21:0] rem_h;
    } t_s4;

    typedef struct packed {
        logic        cmd;
        logic        err0;
        logic [2:0]  dow;
        logic [12:0] wq;
        logic [26:0] tod_rem;
        logic        wk_err;
        logic [8:0]  x;
        logic [12:0] c;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [21:0] rem_h;
    } t_s5;

    typedef struct packed {
        logic        cmd;
        logic        err0;
        logic [12:0] wq;
        logic [29:0] week_ms;
        logic        wk_err;
        logic [4:0]  e;
        logic [8:0]  x;
        logic [12:0] c;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] sec;
    } t_s6;

    typedef struct packed {
        logic    cmd;
        logic    status;
        t_result res;
    } t_s7;

    // pipeline control
    logic [N_STAGES:1] r_vld;
    logic [N_STAGES:1] w_rdy;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;

    // datapath intermediates
    t_item       w_in;
    logic [11:0] w_y4;
    logic [40:0] w_day_prod;
    logic [20:0] w_sum;
    logic [40:0] w_hr_prod;
    logic [56:0] w_c_prod;
    logic [40:0] w_wq_prod;
    logic [21:0] w_d;
    logic [34:0] w_min_prod;
    logic [3:0]  w_mo;

    // A stage takes new data when it is empty or its contents move on, so
    // a stalled output holds every stage and loses nothing.
    always_comb begin
        w_rdy[N_STAGES] = !r_vld[N_STAGES] || i_m_axis_tready;
        for (int s = N_STAGES - 1; s >= 1; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    assign o_s_axis_tready = w_rdy[1];

    // ---------------- stage 1 ----------------
    assign w_in = t_item'(i_s_axis_tdata[FIELDS_W-1:0]);

    always_comb begin
        if (w_in.year < YEAR_2DIG_LIM) begin
            w_y4 = (w_in.year < YEAR_PIVOT) ? w_in.year + CENT_20 : w_in.year + CENT_19;
        end else begin
            w_y4 = w_in.year;
        end

        n_s1.cmd = i_s_axis_tuser[0];
        // January and February count as months 13 and 14 of the year before
        if (w_in.month <= MONTH_FEB) begin
            n_s1.y = w_y4 - 12'd1;
            n_s1.k = 5'(w_in.month) + MONTHS_YR + 5'd1;
        end else begin
            n_s1.y = w_y4;
            n_s1.k = 5'(w_in.month) + 5'd1;
        end
        n_s1.day = w_in.day;
        n_s1.tod = 27'(w_in.hour) * 27'(MS_PER_HOUR) + 27'(w_in.minute) * 27'(MS_PER_MIN)
                   + 27'(w_in.second_ms);

        n_s1.wk7    = 16'(w_in.week) * 16'd7;
        n_s1.wk_err = (32'(w_in.week) >> WEEK_BITS) != 32'd0;
        n_s1.wms    = w_in.week_ms;
        w_day_prod  = 41'(w_in.week_ms[WMS_W-1:DAY_PRE]) * 41'(DAY_M);
        n_s1.dq     = w_day_prod[DAY_SH +: 4];
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        n_s2.cmd = r_s1.cmd;
        // floor(365.25*y) is 365*y + y/4 exactly
        n_s2.yd = 21'(r_s1.y) * 21'(DAYS_PER_YR) + 21'(r_s1.y >> 2)
                  + 21'(f_month_floor(r_s1.k)) + 21'(r_s1.day);
        // oversized time fields never reach two whole days
        n_s2.tod_ge  = r_s1.tod >= MS_PER_DAY;
        n_s2.tod_rem = n_s2.tod_ge ? r_s1.tod - MS_PER_DAY : r_s1.tod;

        n_s2.wk_err = r_s1.wk_err;
        n_s2.b      = 22'(r_s1.wk7) + 22'(r_s1.dq) + CAL_B_OFF;
        n_s2.msday  = 27'(r_s1.wms - 30'(r_s1.dq) * 30'(MS_PER_DAY));
    end

    // ---------------- stage 3 ----------------
    always_comb begin
        n_s3.cmd     = r_s2.cmd;
        w_sum        = r_s2.yd + 21'(r_s2.tod_ge);
        n_s3.neg     = w_sum < CAL_DAY_OFF;
        n_s3.td      = 20'(w_sum - CAL_DAY_OFF);
        n_s3.tod_rem = r_s2.tod_rem;

        n_s3.wk_err = r_s2.wk_err;
        n_s3.b      = r_s2.b;
        n_s3.nc     = 28'(29'(r_s2.b) * 29'd100 - CAL_C_SUB);
        n_s3.msday  = r_s2.msday;
        w_hr_prod   = 41'(r_s2.msday[26:HR_PRE]) * 41'(HR_M);
        n_s3.hour   = w_hr_prod[HR_SH +: HOUR_W];
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        n_s4.cmd     = r_s3.cmd;
        n_s4.neg     = r_s3.neg;
        n_s4.td      = r_s3.td;
        w_wq_prod    = 41'(r_s3.td) * 41'(DIV7_M);
        n_s4.wq      = w_wq_prod[DIV7_SH +: 17];
        n_s4.tod_rem = r_s3.tod_rem;

        n_s4.wk_err = r_s3.wk_err;
        n_s4.b      = r_s3.b;
        w_c_prod    = 57'(r_s3.nc) * 57'(C_M);
        n_s4.c      = w_c_prod[C_SH +: 13];
        n_s4.hour   = r_s3.hour;
        n_s4.rem_h  = 22'(r_s3.msday - 27'(r_s3.hour) * 27'(MS_PER_HOUR));
    end

    // ---------------- stage 5 ----------------
    always_comb begin
        n_s5.cmd     = r_s4.cmd;
        n_s5.dow     = 3'(r_s4.td - 20'(r_s4.wq) * 20'd7);
        n_s5.err0    = r_s4.neg || ((32'(r_s4.wq) >> WEEK_BITS) != 32'd0);
        n_s5.wq      = r_s4.wq[WEEK_W-1:0];
        n_s5.tod_rem = r_s4.tod_rem;

        n_s5.wk_err = r_s4.wk_err;
        w_d         = 22'(r_s4.c) * 22'(DAYS_PER_YR) + 22'(r_s4.c >> 2);
        n_s5.x      = 9'(r_s4.b - w_d);
        n_s5.c      = r_s4.c;
        n_s5.hour   = r_s4.hour;
        w_min_prod  = 35'(r_s4.rem_h[21:MIN_PRE]) * 35'(MIN_M);
        n_s5.minute = w_min_prod[MIN_SH +: MIN_W];
        n_s5.rem_h  = r_s4.rem_h;
    end

    // ---------------- stage 6 ----------------
    always_comb begin
        n_s6.cmd     = r_s5.cmd;
        n_s6.err0    = r_s5.err0;
        n_s6.wq      = r_s5.wq;
        n_s6.week_ms = 30'(r_s5.dow) * 30'(MS_PER_DAY) + 30'(r_s5.tod_rem);

        n_s6.wk_err = r_s5.wk_err;
        // e = floor(x / 30.6001): highest k whose threshold x exceeds
        n_s6.e = 5'd0;
        for (int k = 1; k <= 16; k++) begin
            if (r_s5.x > f_month_floor(5'(k))) begin
                n_s6.e = 5'(k);
            end
        end
        n_s6.x      = r_s5.x;
        n_s6.c      = r_s5.c;
        n_s6.hour   = r_s5.hour;
        n_s6.minute = r_s5.minute;
        n_s6.sec    = 16'(r_s5.rem_h - 22'(r_s5.minute) * 22'(MS_PER_MIN));
    end

    // ---------------- stage 7: result select ----------------
    always_comb begin
        w_mo = (r_s6.e >= E_WRAP) ? 4'(r_s6.e - (E_WRAP - 5'd1)) : 4'(r_s6.e - 5'd1);

        n_s7.cmd    = r_s6.cmd;
        n_s7.status = ST_OK;
        n_s7.res    = '0;
        if (r_s6.cmd == CMD_TO_GPS) begin
            if (r_s6.err0) begin
                n_s7.status = ST_RANGE;
            end else begin
                n_s7.res.out_week    = r_s6.wq;
                n_s7.res.out_week_ms = r_s6.week_ms;
            end
        end else begin
            if (r_s6.wk_err) begin
                n_s7.status = ST_RANGE;
            end else begin
                n_s7.res.out_month     = w_mo;
                n_s7.res.out_day       = 5'(r_s6.x - f_month_floor(r_s6.e));
                n_s7.res.out_year      = 12'(r_s6.c - CAL_YEAR_OFF
                                             - 13'(w_mo >= MONTH_MAR));
                n_s7.res.out_hour      = r_s6.hour;
                n_s7.res.out_minute    = r_s6.minute;
                n_s7.res.out_second_ms = r_s6.sec;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int s = 2; s <= N_STAGES; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[4]) begin
            r_s4 <= n_s4;
        end
        if (w_rdy[5]) begin
            r_s5 <= n_s5;
        end
        if (w_rdy[6]) begin
            r_s6 <= n_s6;
        end
        if (w_rdy[7]) begin
            r_s7 <= n_s7;
        end
    end

    assign o_m_axis_tvalid = r_vld[N_STAGES];
    assign o_m_axis_tdata  = TDATA_W'(r_s7.res);
    assign o_m_axis_tuser  = TUSER_W'(r_s7.status);

    // ---------------- assertions ----------------
    `GTCC_ASSERT(a_range_zeroes_fields, i_clk, i_rst_n, o_m_axis_tvalid && r_s7.status == ST_RANGE, r_s7.res == '0, "range error result carries non-zero fields")
    `GTCC_ASSERT(a_gps_no_calendar, i_clk, i_rst_n, o_m_axis_tvalid && r_s7.cmd == CMD_TO_GPS, r_s7.res.out_year == '0 && r_s7.res.out_month == '0 && r_s7.res.out_day == '0 && r_s7.res.out_hour == '0 && r_s7.res.out_minute == '0 && r_s7.res.out_second_ms == '0, "calendar fields set on GPS result")
    `GTCC_ASSERT(a_cal_month_day, i_clk, i_rst_n, o_m_axis_tvalid && r_s7.cmd == CMD_TO_CAL && r_s7.status == ST_OK, r_s7.res.out_month >= 4'd1 && r_s7.res.out_month <= 4'd12 && r_s7.res.out_day != '0 && r_s7.res.out_week == '0 && r_s7.res.out_week_ms == '0, "calendar result malformed")
    `GTCC_ASSERT(a_empty_tail_ready, i_clk, i_rst_n, !r_vld[N_STAGES], o_s_axis_tready, "input stalled with empty output stage")
    `GTCC_ASSERT_NEXT(a_entry_valid, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[1], "accepted transaction did not enter stage 1")

endmodule
